>>> design/acw_pkg.sv
`timescale 1ns / 1ps

package acw_pkg;

    typedef enum logic [2:0] {
        MODE_HARD       = 3'd0,
        MODE_QUADRATIC  = 3'd1,
        MODE_TANH       = 3'd2,
        MODE_HYPERBOLIC = 3'd3,
        MODE_SIN_ARCTAN = 3'd4
    } t_curve_mode;

    localparam int          SAMPLE_W       = 16;
    localparam int          PADDR_W        = 3;
    localparam logic [14:0] ONE_Q14        = 15'd16384;
    localparam logic [26:0] QUAD_BASE      = 27'd50333184;
    localparam logic [15:0] RECIP_THREE    = 16'd43691;
    localparam int          RECIP_SHIFT    = 17;
    localparam int          SEARCH_BITS    = 15;
    localparam int          FIRST_ITER     = 3;
    localparam int          LAST_STAGE     = FIRST_ITER + SEARCH_BITS;

endpackage

>>> design/audio_clipper_waveshaper_top.sv
`timescale 1ns / 1ps

// Multi-mode clipper: each signed Q3.12 sample becomes a signed Q1.14 sample shaped by the
// curve in curve_mode (hard clip, quadratic soft clip, tanh, x/(1+|x|), x/sqrt(1+x^2)).
// The block takes one transaction per clock while the output is not stalled. The depth of
// its pipeline is set by the 15 one-bit stages that the divider for the hyperbolic curve and
// the root search for the sin-arctan curve run side by side; tanh is a linear interpolation
// in a constant table of TANH_TABLE_DEPTH+1 entries. Each stage holds its contents while the
// stage after it is full and cannot move, so a stall at the output fills the pipeline before
// o_stall rises. curve_mode sits at byte address 0 and should be written only while no
// transaction is in flight.
module audio_clipper_waveshaper_top #(
    parameter int TANH_TABLE_DEPTH = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [15:0]            i_sample_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [15:0]            o_sample_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [acw_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int IW   = $clog2(TANH_TABLE_DEPTH + 1);
    localparam int PW   = 15 + IW;
    localparam int LAST = acw_pkg::LAST_STAGE;
    localparam logic [63:0] TANH_Y = (64'd1 << 34) / TANH_TABLE_DEPTH;

    function automatic logic [63:0] f_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [TANH_TABLE_DEPTH:0][14:0] f_build_rom(input logic [63:0] y);
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] n;
        logic [TANH_TABLE_DEPTH:0][14:0] rom;
        term = 64'd1 << 30;
        r    = 64'd1 << 30;
        e    = 64'd1 << 30;
        rom  = '0;
        for (int k = 1; k <= 12; k++) begin
            term = f_udiv((term * y) >> 30, 64'(k));
            if (k % 2 == 1) begin
                r = r - term;
            end else begin
                r = r + term;
            end
        end
        for (int i = 0; i <= TANH_TABLE_DEPTH; i++) begin
            d      = (64'd1 << 30) + e;
            n      = ((64'd1 << 30) - e) * 64'd32768 + d;
            rom[i] = 15'(f_udiv(n, d << 1));
            e      = (e * r + (64'd1 << 29)) >> 30;
        end
        return rom;
    endfunction

    localparam logic [TANH_TABLE_DEPTH:0][14:0] TANH_ROM = f_build_rom(TANH_Y);

    typedef struct packed {
        logic                v;
        logic                neg;
        logic [2:0]          mode;
        logic [15:0]         a;
        logic [14:0]         hard_m;
        logic [17:0]         a3;
        logic [24:0]         tsq;
        logic [15:0]         qv;
        logic [31:0]         qprod;
        logic [14:0]         quad_m;
        logic [30:0]         asq;
        logic [PW-1:0]       p;
        logic [IW-1:0]       idx;
        logic [14:0]         f;
        logic [14:0]         lo;
        logic [14:0]         hi;
        logic [29:0]         tprod;
        logic [14:0]         tanh_m;
        logic [31:0]         dnum;
        logic [16:0]         dden;
        logic [14:0]         dq;
        logic [30:0]         sn;
        logic [60:0]         rhs;
        logic signed [65:0]  ss;
        logic signed [49:0]  su;
        logic [14:0]         sq;
        logic [15:0]         res;
    } t_stage;

    t_stage      r_pipe [0:LAST];
    t_stage      n_pipe [0:LAST];
    logic        en     [0:LAST];
    logic [2:0]  r_mode;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {29'd0, r_mode};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= acw_pkg::MODE_HARD;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_mode <= pwdata[2:0];
        end
    end

    assign en[LAST] = !r_pipe[LAST].v || !i_stall;
    assign o_stall  = !en[0];
    assign o_valid  = r_pipe[LAST].v;
    assign o_sample_out = $signed(r_pipe[LAST].res);

    genvar s;
    generate
        for (s = 0; s <= LAST; s++) begin : g_stage
            if (s < LAST) begin : g_en
                assign en[s] = !r_pipe[s].v || en[s+1];
            end

            if (s == 0) begin : g_in
                always_comb begin
                    n_pipe[s]      = '0;
                    n_pipe[s].v    = i_valid;
                    n_pipe[s].neg  = i_sample_in[15];
                    n_pipe[s].mode = r_mode;
                    n_pipe[s].a    = i_sample_in[15] ? (~i_sample_in + 16'd1) : i_sample_in;
                end
            end else if (s == 1) begin : g_prep
                always_comb begin
                    n_pipe[s]        = r_pipe[s-1];
                    n_pipe[s].asq    = 31'(r_pipe[s-1].a * r_pipe[s-1].a);
                    n_pipe[s].p      = PW'(r_pipe[s-1].a * TANH_TABLE_DEPTH);
                    n_pipe[s].a3     = 18'(r_pipe[s-1].a) * 18'd3;
                    n_pipe[s].hard_m = (r_pipe[s-1].a >= 16'd4096) ? acw_pkg::ONE_Q14
                                                                   : {r_pipe[s-1].a[12:0], 2'b00};
                    n_pipe[s].dnum   = {1'b0, r_pipe[s-1].a[15:0], 15'd0}
                                       + 32'd4096 + 32'(r_pipe[s-1].a);
                    n_pipe[s].dden   = {(16'd4096 + r_pipe[s-1].a), 1'b0};
                end
            end else if (s == 2) begin : g_init
                logic [12:0] t_val;
                always_comb begin
                    t_val         = 13'(18'd8192 - r_pipe[s-1].a3);
                    n_pipe[s]     = r_pipe[s-1];
                    n_pipe[s].tsq = 25'(t_val * t_val);
                    n_pipe[s].sn  = 31'd16777216 + r_pipe[s-1].asq;
                    n_pipe[s].rhs = {r_pipe[s-1].asq, 30'd0};
                    n_pipe[s].ss  = $signed({35'd0, 31'd16777216 + r_pipe[s-1].asq});
                    n_pipe[s].su  = -$signed({19'd0, 31'd16777216 + r_pipe[s-1].asq});
                    n_pipe[s].sq  = '0;
                    n_pipe[s].dq  = '0;
                    n_pipe[s].idx = r_pipe[s-1].p[PW-1:15];
                    n_pipe[s].f   = r_pipe[s-1].p[14:0];
                end
            end else if (s < LAST) begin : g_iter
                localparam int K = LAST - 1 - s;
                logic [31:0]        d_cand;
                logic signed [65:0] s_cand;
                logic signed [49:0] u_cand;
                logic [IW-1:0]      hi_idx;
                logic [26:0]        q_num;
                logic [30:0]        t_sum;
                always_comb begin
                    n_pipe[s] = r_pipe[s-1];
                    d_cand    = 32'(r_pipe[s-1].dden) << K;
                    if (r_pipe[s-1].dnum >= d_cand) begin
                        n_pipe[s].dnum  = r_pipe[s-1].dnum - d_cand;
                        n_pipe[s].dq[K] = 1'b1;
                    end
                    s_cand = r_pipe[s-1].ss
                             + (66'(r_pipe[s-1].su) <<< (K + 2))
                             + ($signed({35'd0, r_pipe[s-1].sn}) <<< (2 * K + 2));
                    u_cand = r_pipe[s-1].su + ($signed({19'd0, r_pipe[s-1].sn}) <<< (K + 1));
                    if (s_cand <= $signed({5'd0, r_pipe[s-1].rhs})) begin
                        n_pipe[s].ss    = s_cand;
                        n_pipe[s].su    = u_cand;
                        n_pipe[s].sq[K] = 1'b1;
                    end
                    hi_idx = (32'(r_pipe[s-1].idx) == TANH_TABLE_DEPTH) ? r_pipe[s-1].idx
                                                                        : r_pipe[s-1].idx + 1'b1;
                    q_num  = acw_pkg::QUAD_BASE - 27'(r_pipe[s-1].tsq);
                    t_sum  = {1'b0, r_pipe[s-1].lo, 15'd0} + 31'(r_pipe[s-1].tprod) + 31'd16384;
                    if (s == acw_pkg::FIRST_ITER) begin
                        n_pipe[s].lo = TANH_ROM[r_pipe[s-1].idx];
                        n_pipe[s].hi = TANH_ROM[hi_idx];
                        n_pipe[s].qv = q_num[25:10];
                    end
                    if (s == acw_pkg::FIRST_ITER + 1) begin
                        n_pipe[s].tprod = 30'((r_pipe[s-1].hi - r_pipe[s-1].lo) * r_pipe[s-1].f);
                        n_pipe[s].qprod = 32'(r_pipe[s-1].qv * acw_pkg::RECIP_THREE);
                    end
                    if (s == acw_pkg::FIRST_ITER + 2) begin
                        n_pipe[s].tanh_m = (t_sum[30:15] > 16'(acw_pkg::ONE_Q14))
                                           ? acw_pkg::ONE_Q14 : t_sum[29:15];
                        if (r_pipe[s-1].a3 < 18'd4096) begin
                            n_pipe[s].quad_m = {r_pipe[s-1].a[11:0], 3'b000};
                        end else if (r_pipe[s-1].a3 < 18'd8192) begin
                            n_pipe[s].quad_m = 15'(r_pipe[s-1].qprod >> acw_pkg::RECIP_SHIFT);
                        end else begin
                            n_pipe[s].quad_m = acw_pkg::ONE_Q14;
                        end
                    end
                end
            end else begin : g_out
                logic [14:0] m_sel;
                always_comb begin
                    case (r_pipe[s-1].mode)
                        acw_pkg::MODE_QUADRATIC:  m_sel = r_pipe[s-1].quad_m;
                        acw_pkg::MODE_TANH:       m_sel = r_pipe[s-1].tanh_m;
                        acw_pkg::MODE_HYPERBOLIC: m_sel = r_pipe[s-1].dq;
                        acw_pkg::MODE_SIN_ARCTAN: m_sel = r_pipe[s-1].sq;
                        default:                  m_sel = r_pipe[s-1].hard_m;
                    endcase
                    n_pipe[s]     = r_pipe[s-1];
                    n_pipe[s].res = r_pipe[s-1].neg ? (16'd0 - {1'b0, m_sel}) : {1'b0, m_sel};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_pipe[s].v <= 1'b0;
                end else if (en[s]) begin
                    r_pipe[s] <= n_pipe[s];
                end
            end
        end
    endgenerate

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sample_out <= 16'sd16384 && o_sample_out >= -16'sd16384))
        else $error("Result lies outside plus or minus one.");

    a_search_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pipe[LAST-1].v |-> (r_pipe[LAST-1].sq <= acw_pkg::ONE_Q14
                              && r_pipe[LAST-1].dq <= acw_pkg::ONE_Q14))
        else $error("Quotient or root search exceeded one.");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pipe[0].v && r_pipe[1].v && r_pipe[LAST].v && i_stall && !en[1]) |-> o_stall)
        else $error("Input accepted while the first stage cannot move.");

    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_pipe[LAST].neg) |-> !o_sample_out[15])
        else $error("Result of a non-negative sample came out negative.");

endmodule
